[src/sia_pkg.sv]
// Shared types and constants for the segment intersection unit.
`timescale 1ns / 1ps
package sia_pkg;

  // Tolerance register width
  localparam int TOL_WIDTH = 32;

  // Result tuser layout
  localparam int USER_WIDTH = 2;
  localparam int USER_HIT   = 0;
  localparam int USER_DEGEN = 1;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } sia_qstat_t;

  // Width of one queued job for a given coordinate width
  function automatic int sia_job_width(input int coord_w);
    return 8 * coord_w + 10;
  endfunction

endpackage

[src/sia_queue.sv]
// Small register queue between the classify front and the point back end.
`timescale 1ns / 1ps
module sia_queue import sia_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output sia_qstat_t       stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = mem[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("queue pop while empty");

endmodule

[src/sia_front.sv]
// Front end: bounding box and straddle tests, classification of each pair.
`timescale 1ns / 1ps
module sia_front import sia_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  localparam int JW = sia_job_width(COORD_WIDTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [8*COORD_WIDTH-1:0] s_tdata,
  input  logic [TOL_WIDTH-1:0]     tol,
  input  sia_qstat_t               qstat,
  output logic                     push,
  output logic [JW-1:0]            push_data
);

  localparam int W   = COORD_WIDTH;
  localparam int DW1 = W + 1;
  localparam int PW  = 2 * DW1;
  localparam int SW  = PW + 1;
  localparam int MW  = (SW > 33) ? SW : 33;

  logic en;
  logic v1, v2, v3, v4, v5;

  // Input fields
  logic signed [W-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  assign asx = $signed(s_tdata[0*W +: W]);
  assign asy = $signed(s_tdata[1*W +: W]);
  assign aex = $signed(s_tdata[2*W +: W]);
  assign aey = $signed(s_tdata[3*W +: W]);
  assign bsx = $signed(s_tdata[4*W +: W]);
  assign bsy = $signed(s_tdata[5*W +: W]);
  assign bex = $signed(s_tdata[6*W +: W]);
  assign bey = $signed(s_tdata[7*W +: W]);

  // Bounding boxes
  logic signed [W-1:0] aminx, amaxx, aminy, amaxy, bminx, bmaxx, bminy, bmaxy;
  logic box_rej_c;
  always_comb begin
    aminx = (asx < aex) ? asx : aex;
    amaxx = (asx < aex) ? aex : asx;
    aminy = (asy < aey) ? asy : aey;
    amaxy = (asy < aey) ? aey : asy;
    bminx = (bsx < bex) ? bsx : bex;
    bmaxx = (bsx < bex) ? bex : bsx;
    bminy = (bsy < bey) ? bsy : bey;
    bmaxy = (bsy < bey) ? bey : bsy;
    box_rej_c = (amaxx < bminx) || (bmaxx < aminx) || (amaxy < bminy) || (bmaxy < aminy);
  end

  // Stage 1 registers: normals and offsets
  logic signed [DW1-1:0] n1x, n1y, n2x, n2y, e1x, e1y, f1x, f1y, hx, hy, g2x, g2y;
  logic signed [W-1:0]   bsx1, bsy1;
  logic                  rej1;
  // Stage 2 registers: products
  logic signed [PW-1:0]  p1a, p1b, p1c, p1d, p2a, p2b, p2c, p2d, pda, pdb;
  logic signed [DW1-1:0] dbx2, dby2;
  logic signed [W-1:0]   bsx2, bsy2;
  logic                  rej2;
  // Stage 3 registers: distances and denominator
  logic signed [SW-1:0]  d1s, d1e, d2s, d2e, den3;
  logic signed [DW1-1:0] dbx3, dby3;
  logic signed [W-1:0]   bsx3, bsy3;
  logic                  rej3;
  // Stage 4 registers: magnitudes and sign checks
  logic [MW-1:0]         m1s, m1e, m2s, m2e;
  logic                  pass1_4, pass2_4, dz4, rej4;
  logic signed [SW-1:0]  d1s4, den4;
  logic signed [DW1-1:0] dbx4, dby4;
  logic signed [W-1:0]   bsx4, bsy4;
  // Stage 5 registers: distance products
  logic [63:0]           prod1, prod2;
  logic                  big1, big2, pass1_5, pass2_5, dz5, rej5;
  logic signed [SW-1:0]  d1s5, den5;
  logic signed [DW1-1:0] dbx5, dby5;
  logic signed [W-1:0]   bsx5, bsy5;

  assign en       = !v5 || !qstat.full;
  assign s_tready = en;
  assign push     = v5 && !qstat.full;

  // Advance valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      n1x  <= DW1'(aey) - DW1'(asy);
      n1y  <= DW1'(asx) - DW1'(aex);
      n2x  <= DW1'(bey) - DW1'(bsy);
      n2y  <= DW1'(bsx) - DW1'(bex);
      e1x  <= DW1'(bsx) - DW1'(asx);
      e1y  <= DW1'(bsy) - DW1'(asy);
      f1x  <= DW1'(bex) - DW1'(asx);
      f1y  <= DW1'(bey) - DW1'(asy);
      hx   <= DW1'(asx) - DW1'(bsx);
      hy   <= DW1'(asy) - DW1'(bsy);
      g2x  <= DW1'(aex) - DW1'(bsx);
      g2y  <= DW1'(aey) - DW1'(bsy);
      bsx1 <= bsx;
      bsy1 <= bsy;
      rej1 <= box_rej_c;

      p1a  <= PW'(n1x) * PW'(e1x);
      p1b  <= PW'(n1y) * PW'(e1y);
      p1c  <= PW'(n1x) * PW'(f1x);
      p1d  <= PW'(n1y) * PW'(f1y);
      p2a  <= PW'(n2x) * PW'(hx);
      p2b  <= PW'(n2y) * PW'(hy);
      p2c  <= PW'(n2x) * PW'(g2x);
      p2d  <= PW'(n2y) * PW'(g2y);
      pda  <= PW'(n2x) * PW'(n1y);
      pdb  <= PW'(n2y) * PW'(n1x);
      dbx2 <= -n2y;
      dby2 <= n2x;
      bsx2 <= bsx1;
      bsy2 <= bsy1;
      rej2 <= rej1;

      d1s  <= SW'(p1a) + SW'(p1b);
      d1e  <= SW'(p1c) + SW'(p1d);
      d2s  <= SW'(p2a) + SW'(p2b);
      d2e  <= SW'(p2c) + SW'(p2d);
      den3 <= SW'(pda) - SW'(pdb);
      dbx3 <= dbx2;
      dby3 <= dby2;
      bsx3 <= bsx2;
      bsy3 <= bsy2;
      rej3 <= rej2;

      // Zero or opposite signs always pass
      pass1_4 <= (d1s == '0) || (d1e == '0) || (d1s[SW-1] != d1e[SW-1]);
      pass2_4 <= (d2s == '0) || (d2e == '0) || (d2s[SW-1] != d2e[SW-1]);
      m1s  <= MW'(d1s[SW-1] ? -d1s : d1s);
      m1e  <= MW'(d1e[SW-1] ? -d1e : d1e);
      m2s  <= MW'(d2s[SW-1] ? -d2s : d2s);
      m2e  <= MW'(d2e[SW-1] ? -d2e : d2e);
      dz4  <= (den3 == '0);
      d1s4 <= d1s;
      den4 <= den3;
      dbx4 <= dbx3;
      dby4 <= dby3;
      bsx4 <= bsx3;
      bsy4 <= bsy3;
      rej4 <= rej3;

      // Magnitudes of 2^32 or more always exceed the tolerance
      big1    <= (|m1s[MW-1:32]) || (|m1e[MW-1:32]);
      big2    <= (|m2s[MW-1:32]) || (|m2e[MW-1:32]);
      prod1   <= 64'(m1s[31:0]) * 64'(m1e[31:0]);
      prod2   <= 64'(m2s[31:0]) * 64'(m2e[31:0]);
      pass1_5 <= pass1_4;
      pass2_5 <= pass2_4;
      dz5     <= dz4;
      d1s5    <= d1s4;
      den5    <= den4;
      dbx5    <= dbx4;
      dby5    <= dby4;
      bsx5    <= bsx4;
      bsy5    <= bsy4;
      rej5    <= rej4;
    end
  end

  // Classify and pack the job
  logic ex1, ex2, hit_c, degen_c;
  always_comb begin
    ex1       = !pass1_5 && (big1 || (prod1 > 64'(tol)));
    ex2       = !pass2_5 && (big2 || (prod2 > 64'(tol)));
    hit_c     = !(rej5 || ex1 || ex2);
    degen_c   = hit_c && dz5;
    push_data = {dby5, dbx5, bsy5, bsx5, den5, d1s5, degen_c, hit_c};
  end

endmodule

[src/sia_back.sv]
// Back end: intersection numerators and pipelined restoring division.
`timescale 1ns / 1ps
module sia_back import sia_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  localparam int JW = sia_job_width(COORD_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [JW-1:0]          job,
  input  sia_qstat_t             qstat,
  output logic                   pop,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic                   res_hit,
  output logic                   res_degen,
  output logic [COORD_WIDTH-1:0] res_x,
  output logic [COORD_WIDTH-1:0] res_y
);

  localparam int W   = COORD_WIDTH;
  localparam int DW1 = W + 1;
  localparam int SW  = 2 * DW1 + 1;
  localparam int H   = (SW + 1) / 2;
  localparam int LW  = DW1 + H + 1;
  localparam int HW  = DW1 + SW - H;
  localparam int NW  = 3 * W + 5;
  localparam int QW  = W - 1;
  localparam int NST = W - 1;

  logic en;
  assign en  = !res_valid || res_ready;
  assign pop = en && !qstat.empty;

  // Unpack the job
  logic                  j_hit, j_dg;
  logic signed [SW-1:0]  j_d1s, j_den;
  logic signed [W-1:0]   j_bsx, j_bsy;
  logic signed [DW1-1:0] j_dbx, j_dby;
  assign j_hit = job[0];
  assign j_dg  = job[1];
  assign j_d1s = $signed(job[2 +: SW]);
  assign j_den = $signed(job[2 + SW +: SW]);
  assign j_bsx = $signed(job[2 + 2*SW +: W]);
  assign j_bsy = $signed(job[2 + 2*SW + W +: W]);
  assign j_dbx = $signed(job[2 + 2*SW + 2*W +: DW1]);
  assign j_dby = $signed(job[2 + 2*SW + 2*W + DW1 +: DW1]);

  // Split the wide factors into a low unsigned and a high signed half
  logic signed [H:0]    den_lo, d1s_lo;
  logic signed [SW-H-1:0] den_hi, d1s_hi;
  assign den_lo = $signed({1'b0, j_den[H-1:0]});
  assign d1s_lo = $signed({1'b0, j_d1s[H-1:0]});
  assign den_hi = $signed(j_den[SW-1:H]);
  assign d1s_hi = $signed(j_d1s[SW-1:H]);

  logic v1, v2, v3, v4;
  logic [NST:0] dv;

  // Stage 1: partial products
  logic signed [LW-1:0] bx_lo, by_lo, dx_lo, dy_lo;
  logic signed [HW-1:0] bx_hi, by_hi, dx_hi, dy_hi;
  logic signed [SW-1:0] den1, den2, den3;
  logic                 hit1, dg1, hit2, dg2, hit3, dg3, hit4, dg4;
  // Stage 2: full products
  logic signed [NW-1:0] sbx, sby, sdx, sdy;
  // Stage 3: numerators
  logic signed [NW-1:0] nx, ny;
  // Stage 4: magnitudes and quotient signs
  logic [NW-1:0]        nmx, nmy;
  logic [SW-1:0]        dm4;
  logic                 negx4, negy4;
  // Divider stages, index 0 holds the range check
  logic [NW-1:0]        rx [0:NST-1];
  logic [NW-1:0]        ry [0:NST-1];
  logic [QW-1:0]        qx [0:NST];
  logic [QW-1:0]        qy [0:NST];
  logic [SW-1:0]        dm [0:NST-1];
  logic                 negx [0:NST];
  logic                 negy [0:NST];
  logic                 ovfx [0:NST];
  logic                 ovfy [0:NST];
  logic                 hitp [0:NST];
  logic                 dgp  [0:NST];

  // Advance valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      dv        <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= !qstat.empty;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      dv        <= {dv[NST-1:0], v4};
      res_valid <= dv[NST];
    end
  end

  // Numerator pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      bx_lo <= LW'(j_bsx) * LW'(den_lo);
      bx_hi <= HW'(j_bsx) * HW'(den_hi);
      by_lo <= LW'(j_bsy) * LW'(den_lo);
      by_hi <= HW'(j_bsy) * HW'(den_hi);
      dx_lo <= LW'(d1s_lo) * LW'(j_dbx);
      dx_hi <= HW'(d1s_hi) * HW'(j_dbx);
      dy_lo <= LW'(d1s_lo) * LW'(j_dby);
      dy_hi <= HW'(d1s_hi) * HW'(j_dby);
      den1  <= j_den;
      hit1  <= j_hit;
      dg1   <= j_dg;

      sbx  <= (NW'(bx_hi) <<< H) + NW'(bx_lo);
      sby  <= (NW'(by_hi) <<< H) + NW'(by_lo);
      sdx  <= (NW'(dx_hi) <<< H) + NW'(dx_lo);
      sdy  <= (NW'(dy_hi) <<< H) + NW'(dy_lo);
      den2 <= den1;
      hit2 <= hit1;
      dg2  <= dg1;

      nx   <= sbx - sdx;
      ny   <= sby - sdy;
      den3 <= den2;
      hit3 <= hit2;
      dg3  <= dg2;

      nmx   <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      nmy   <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      dm4   <= den3[SW-1] ? SW'(-den3) : SW'(den3);
      negx4 <= nx[NW-1] ^ den3[SW-1];
      negy4 <= ny[NW-1] ^ den3[SW-1];
      hit4  <= hit3;
      dg4   <= dg3;
    end
  end

  // Range check, then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      ovfx[0] <= nmx >= (NW'(dm4) << (W - 1));
      ovfy[0] <= nmy >= (NW'(dm4) << (W - 1));
      rx[0]   <= nmx;
      ry[0]   <= nmy;
      qx[0]   <= '0;
      qy[0]   <= '0;
      dm[0]   <= dm4;
      negx[0] <= negx4;
      negy[0] <= negy4;
      hitp[0] <= hit4;
      dgp[0]  <= dg4;
      for (int k = 0; k < NST; k++) begin
        if (rx[k] >= (NW'(dm[k]) << (NST - 1 - k))) begin
          qx[k+1] <= qx[k] | (QW'(1) << (NST - 1 - k));
          if (k < NST - 1) begin
            rx[k+1] <= rx[k] - (NW'(dm[k]) << (NST - 1 - k));
          end
        end else begin
          qx[k+1] <= qx[k];
          if (k < NST - 1) begin
            rx[k+1] <= rx[k];
          end
        end
        if (ry[k] >= (NW'(dm[k]) << (NST - 1 - k))) begin
          qy[k+1] <= qy[k] | (QW'(1) << (NST - 1 - k));
          if (k < NST - 1) begin
            ry[k+1] <= ry[k] - (NW'(dm[k]) << (NST - 1 - k));
          end
        end else begin
          qy[k+1] <= qy[k];
          if (k < NST - 1) begin
            ry[k+1] <= ry[k];
          end
        end
        if (k < NST - 1) begin
          dm[k+1] <= dm[k];
        end
        negx[k+1] <= negx[k];
        negy[k+1] <= negy[k];
        ovfx[k+1] <= ovfx[k];
        ovfy[k+1] <= ovfy[k];
        hitp[k+1] <= hitp[k];
        dgp[k+1]  <= dgp[k];
      end
    end
  end

  // Apply sign, saturate and mask rejected or parallel results
  logic [W-1:0] px_c, py_c;
  logic         keep;
  always_comb begin
    keep = hitp[NST] && !dgp[NST];
    if (ovfx[NST]) begin
      px_c = negx[NST] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      px_c = negx[NST] ? W'(0) - W'(qx[NST]) : W'(qx[NST]);
    end
    if (ovfy[NST]) begin
      py_c = negy[NST] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      py_c = negy[NST] ? W'(0) - W'(qy[NST]) : W'(qy[NST]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      res_hit   <= hitp[NST];
      res_degen <= dgp[NST];
      res_x     <= keep ? px_c : '0;
      res_y     <= keep ? py_c : '0;
    end
  end

endmodule

[src/segment_intersection_2d_unit.sv]
// Top level of the 2D segment intersection unit.
// Takes one pair of segments per beat and returns one result beat per pair, in
// order, at a sustained rate of one pair per clock while m_tready stays high. A
// pair passes through five classify stages, one queue slot, the numerator stages
// and the range check, COORD_WIDTH - 1 divider stages (one quotient bit each) and
// the output register. The queue between the classify front and the divider back
// end holds four pairs. straddle_tolerance is written through cfg_valid/cfg_data
// and cfg_ready is always high; the last classify stage reads the register, so
// write it only while no pair is in flight.
`timescale 1ns / 1ps
module segment_intersection_2d_unit import sia_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int JW = sia_job_width(COORD_WIDTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [TOL_WIDTH-1:0]     cfg_data,    // straddle_tolerance
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_WIDTH-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_W-1:0]         m_tdata,     // point_x, point_y, zero pad
  output logic [USER_WIDTH-1:0]    m_tuser      // hit, degenerate
);

  logic [TOL_WIDTH-1:0]   tol;
  logic                   push, pop;
  logic [JW-1:0]          push_data, pop_data;
  sia_qstat_t             qstat;
  logic                   r_hit, r_dg;
  logic [COORD_WIDTH-1:0] r_x, r_y;

  // Hold the tolerance register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  sia_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .tol       (tol),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  sia_queue #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  sia_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_data),
    .qstat     (qstat),
    .pop       (pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_hit   (r_hit),
    .res_degen (r_dg),
    .res_x     (r_x),
    .res_y     (r_y)
  );

  // Pack the result beat
  always_comb begin
    m_tuser             = '0;
    m_tuser[USER_HIT]   = r_hit;
    m_tuser[USER_DEGEN] = r_dg;
    m_tdata             = OUT_W'({r_y, r_x});
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_DEGEN] |-> m_tuser[USER_HIT] && m_tdata == '0)
    else $error("degenerate result without hit or with a point");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[USER_HIT] |-> !m_tuser[USER_DEGEN] && m_tdata == '0)
    else $error("rejected pair with nonzero result");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> qstat.full)
    else $error("input stalled while queue has room");

endmodule
